[rtl/bpc_pkg.sv]
package bpc_pkg;

  localparam logic [23:0] PRESSURE_MAX = 24'hFFFFFF;

  // Configuration register indexes.
  localparam logic [1:0] REG_CURVE_LOW  = 2'd0;
  localparam logic [1:0] REG_CURVE_MID  = 2'd1;
  localparam logic [1:0] REG_CURVE_HIGH = 2'd2;
  localparam logic [1:0] REG_MID_OFFSET = 2'd3;

  typedef struct packed {
    logic signed [15:0] curve_low;
    logic signed [15:0] curve_mid;
    logic signed [15:0] curve_high;
    logic signed [15:0] mid_offset;
  } coeffs_t;

  // One classified sample handed from the front end to the solver.
  typedef struct packed {
    logic signed [33:0] xp;
    logic signed [40:0] den;
    logic signed [39:0] e1x5;
    logic signed [36:0] e2;
    logic signed [37:0] xpe1;
    logic               bad;
    logic signed [16:0] temp;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_COMB,
    B_SCALE,
    B_CHECK,
    B_DIV,
    B_FIN,
    B_DONE
  } back_state_t;

endpackage

[rtl/bpc_front.sv]
module bpc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [23:0]     raw_pressure,
  input  logic [15:0]     raw_temperature,
  input  bpc_pkg::coeffs_t coeffs,
  output logic            job_valid,
  input  logic            job_ready,
  output bpc_pkg::job_t   job
);
  import bpc_pkg::*;

  logic en;
  logic va, vb, vc, vd;

  logic signed [15:0] t;
  logic [23:0]        tprod;

  logic [23:0]        a_rp, b_rp;
  logic signed [31:0] a_tt;
  logic signed [16:0] a_temp, b_temp, c_temp, d_temp;
  logic signed [47:0] b_prod0, b_prod1, b_prod2;

  logic signed [31:0] tq0, tq1, tq2;
  logic signed [33:0] s0, xp;
  logic signed [35:0] s1, s2;
  logic signed [36:0] e1, e2;

  logic signed [33:0] c_xp;
  logic signed [36:0] c_e1, c_e2;

  logic signed [33:0] d_xp;
  logic signed [40:0] d_den;
  logic signed [39:0] d_e1x5;
  logic signed [36:0] d_e2;
  logic signed [37:0] d_xpe1;
  logic               d_e1_zero;

  function automatic logic signed [31:0] trunc16(input logic signed [47:0] p);
    logic signed [47:0] s;
    s = p + (p[47] ? 48'sd65535 : 48'sd0);
    return $signed(s[47:16]);
  endfunction

  // The whole pipe moves together; it stops only when the last stage is full
  // and the queue cannot take its word.
  assign en        = !vd || job_ready;
  assign in_ready  = en;
  assign job_valid = vd;

  // raw_temperature - 32768 is the raw word with its top bit flipped.
  assign t     = $signed({~raw_temperature[15], raw_temperature[14:0]});
  assign tprod = 24'(raw_temperature) * 24'd175;

  assign tq0 = trunc16(b_prod0);
  assign tq1 = trunc16(b_prod1);
  assign tq2 = trunc16(b_prod2);
  assign s0  = 34'sd939524096 + tq0;
  assign s1  = (36'(coeffs.mid_offset) <<< 19) + tq1;
  assign s2  = 36'sd3087007744 + tq2;
  assign xp  = $signed({2'b00, b_rp, 8'h00}) - s0;
  assign e1  = s1 - s0;
  assign e2  = s2 - s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rp    <= raw_pressure;
      a_tt    <= t * t;
      a_temp  <= $signed({1'b0, tprod[23:8]}) - 17'sd11520;

      b_rp    <= a_rp;
      b_temp  <= a_temp;
      b_prod0 <= coeffs.curve_low * a_tt;
      b_prod1 <= coeffs.curve_mid * a_tt;
      b_prod2 <= coeffs.curve_high * a_tt;

      c_xp    <= xp;
      c_e1    <= e1;
      c_e2    <= e2;
      c_temp  <= b_temp;

      d_xp      <= c_xp;
      d_den     <= (c_e1 <<< 3) + (c_e1 <<< 2) - ((c_e2 <<< 3) - c_e2);
      d_e1x5    <= (c_e1 <<< 2) + c_e1;
      d_e2      <= c_e2;
      d_xpe1    <= c_xp - c_e1;
      d_e1_zero <= (c_e1 == 37'sd0);
      d_temp    <= c_temp;
    end
  end

  always_comb begin
    job.xp   = d_xp;
    job.den  = d_den;
    job.e1x5 = d_e1x5;
    job.e2   = d_e2;
    job.xpe1 = d_xpe1;
    job.bad  = d_e1_zero || (d_den == 41'sd0);
    job.temp = d_temp;
  end

endmodule

[rtl/bpc_queue.sv]
module bpc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  bpc_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bpc_pkg::job_t pop_data
);
  import bpc_pkg::*;

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

[rtl/bpc_back.sv]
module bpc_back #(
  parameter int PRESSURE_FRACTION_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  bpc_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        pressure_q6,
  output logic signed [16:0] temperature_q8,
  output logic               out_of_range
);
  import bpc_pkg::*;

  localparam logic [47:0]        SCALE_K = 48'(175000 << PRESSURE_FRACTION_BITS);
  localparam logic signed [42:0] P_BASE  = 43'(80000 << PRESSURE_FRACTION_BITS);
  localparam logic [5:0]         MUL_LAST = 6'd5;
  localparam logic [5:0]         DIV_LAST = 6'd40;

  back_state_t state, state_next;

  logic [79:0]  ma1, ma2, ma3;
  logic [47:0]  mb1, mb2, mb3;
  logic [103:0] acc1, acc2, acc3;
  logic         neg1, neg2, nneg, qneg;
  logic [5:0]   cnt;
  logic [79:0]  qmag, rem;
  logic [40:0]  nlow, quo;
  logic [23:0]  res_p;
  logic         res_flag;
  logic signed [16:0] temp;

  logic signed [81:0] p1s, p2s, qs;
  logic               qneg_w;
  logic [79:0]        qmag_w;
  logic               ovf_early;
  logic [80:0]        trial;
  logic               ge;
  logic               rneg;
  logic               quo_big;
  logic signed [42:0] pv;
  logic               load_out;

  function automatic logic [79:0] mag80(input logic signed [79:0] v);
    return v[79] ? 80'(-v) : 80'(v);
  endfunction

  assign p1s    = neg1 ? -$signed({2'b00, acc1[79:0]}) : $signed({2'b00, acc1[79:0]});
  assign p2s    = neg2 ? -$signed({2'b00, acc2[79:0]}) : $signed({2'b00, acc2[79:0]});
  assign qs     = p1s - p2s;
  assign qneg_w = qs[81];
  assign qmag_w = qneg_w ? 80'(-qs) : 80'(qs);

  assign ovf_early = {17'd0, acc3} >= {qmag, 41'd0};
  assign trial     = {rem, nlow[40]};
  assign ge        = trial >= {1'b0, qmag};
  assign rneg      = nneg ^ qneg;
  assign quo_big   = quo[40] && (quo[39:0] != 40'd0);
  assign pv        = rneg ? P_BASE + $signed({2'b00, quo}) : P_BASE - $signed({2'b00, quo});
  assign load_out  = (state == B_DONE) && (!out_valid || out_ready);
  assign job_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (job_valid) state_next = job.bad ? B_DONE : B_MUL;
      B_MUL:   if (cnt == MUL_LAST) state_next = B_COMB;
      B_COMB:  state_next = (qmag_w == 80'd0) ? B_DONE : B_SCALE;
      B_SCALE: if (cnt == MUL_LAST) state_next = B_CHECK;
      B_CHECK: state_next = ovf_early ? B_DONE : B_DIV;
      B_DIV:   if (cnt == DIV_LAST) state_next = B_FIN;
      B_FIN:   state_next = B_DONE;
      B_DONE:  if (load_out) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Datapath: three shift-add multipliers (8 bits a step), then one
  // restoring divider producing one quotient bit a cycle.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        ma1  <= mag80(job.den);
        mb1  <= 48'(mag80(job.xp));
        ma2  <= mag80(job.e1x5);
        mb2  <= 48'(mag80(job.e2));
        ma3  <= mag80(job.e2);
        mb3  <= 48'(mag80(job.xpe1));
        neg1 <= job.xp[33] ^ job.den[40];
        neg2 <= job.e1x5[39] ^ job.e2[36];
        nneg <= job.e2[36] ^ job.xpe1[37];
        temp <= job.temp;
        acc1 <= '0;
        acc2 <= '0;
        acc3 <= '0;
        cnt  <= '0;
        res_p    <= PRESSURE_MAX;
        res_flag <= 1'b1;
      end
      B_MUL, B_SCALE: begin
        acc1 <= (acc1 << 8) + 104'(ma1) * 104'(mb1[47:40]);
        acc2 <= (acc2 << 8) + 104'(ma2) * 104'(mb2[47:40]);
        acc3 <= (acc3 << 8) + 104'(ma3) * 104'(mb3[47:40]);
        mb1  <= mb1 << 8;
        mb2  <= mb2 << 8;
        mb3  <= mb3 << 8;
        cnt  <= (cnt == MUL_LAST) ? 6'd0 : cnt + 6'd1;
      end
      B_COMB: begin
        qmag <= qmag_w;
        qneg <= qneg_w;
        ma3  <= acc3[79:0];
        mb3  <= SCALE_K;
        acc3 <= '0;
        cnt  <= '0;
      end
      B_CHECK: begin
        rem  <= 80'(acc3 >> 41);
        nlow <= acc3[40:0];
        quo  <= '0;
        cnt  <= '0;
        if (ovf_early) begin
          res_p    <= rneg ? PRESSURE_MAX : 24'd0;
          res_flag <= 1'b1;
        end
      end
      B_DIV: begin
        rem  <= ge ? 80'(trial - {1'b0, qmag}) : trial[79:0];
        quo  <= {quo[39:0], ge};
        nlow <= nlow << 1;
        cnt  <= cnt + 6'd1;
      end
      B_FIN: begin
        if (quo_big) begin
          res_p    <= rneg ? PRESSURE_MAX : 24'd0;
          res_flag <= 1'b1;
        end else if (pv < 43'sd0) begin
          res_p    <= 24'd0;
          res_flag <= 1'b1;
        end else if (pv > $signed({19'd0, PRESSURE_MAX})) begin
          res_p    <= PRESSURE_MAX;
          res_flag <= 1'b1;
        end else begin
          res_p    <= pv[23:0];
          res_flag <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pressure_q6    <= res_p;
      temperature_q8 <= temp;
      out_of_range   <= res_flag;
    end
  end

endmodule

[rtl/baro_pressure_compensation_unit.sv]
// Path: front-end stages a to d, a two-entry queue, then the solver's multiply,
// combine, scale, check, divide and finish steps and its output register; a
// sample with no valid curve fit skips straight to the output, one with a zero
// rational divisor leaves after combine. The solver takes a new sample only in
// idle, paced by its 8-bit multiply steps and one-bit-a-cycle divider.
// Synchronous active-high reset clears the pipe, queue, solver and registers.
module baro_pressure_compensation_unit #(
  parameter int PRESSURE_FRACTION_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        raw_pressure,
  input  logic [15:0]        raw_temperature,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        pressure_q6,
  output logic signed [16:0] temperature_q8,
  output logic               out_of_range,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import bpc_pkg::*;

  coeffs_t coeffs;
  job_t    f_job, q_job;
  logic    f_valid, f_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CURVE_LOW:  coeffs.curve_low  <= $signed(cfg_data);
        REG_CURVE_MID:  coeffs.curve_mid  <= $signed(cfg_data);
        REG_CURVE_HIGH: coeffs.curve_high <= $signed(cfg_data);
        REG_MID_OFFSET: coeffs.mid_offset <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  bpc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .coeffs          (coeffs),
    .job_valid       (f_valid),
    .job_ready       (f_ready),
    .job             (f_job)
  );

  bpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  bpc_back #(
    .PRESSURE_FRACTION_BITS (PRESSURE_FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_valid),
    .job_ready      (q_ready),
    .job            (q_job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pressure_q6    (pressure_q6),
    .temperature_q8 (temperature_q8),
    .out_of_range   (out_of_range)
  );

endmodule

[rtl/bpc_checker.sv]
module bpc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [23:0]        pressure_q6,
  input logic signed [16:0] temperature_q8,
  input logic               out_of_range
);

  logic [7:0] pending;

  // Samples taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_q6) &&
      $stable(temperature_q8) && $stable(out_of_range))
    else $error("output word changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("output word without a pending sample");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temperature_q8 >= -17'sd11520 && temperature_q8 <= 17'sd33280)
    else $error("temperature out of range");

endmodule

bind baro_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .pressure_q6    (pressure_q6),
  .temperature_q8 (temperature_q8),
  .out_of_range   (out_of_range)
);
